[design/tdpt_pkg.sv]
package tdpt_pkg;

    // default operand width
    localparam int DEFAULT_WORD_BITS = 32;

    // smallest trial divisor, also the smallest prime
    localparam int FIRST_DIVISOR = 2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_BOUND,
        S_DIV
    } t_state;

    // width of the trial divisor: one bit more than the square root of the largest operand needs
    function automatic int divisor_bits(input int word_bits);
        return (word_bits + 1) / 2 + 1;
    endfunction

endpackage

[design/tdpt_rem_unit.sv]
module tdpt_rem_unit #(
    parameter int WORD_BITS = tdpt_pkg::DEFAULT_WORD_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [WORD_BITS-1:0]                         i_dividend,
    input  logic [tdpt_pkg::divisor_bits(WORD_BITS)-1:0] i_divisor,
    output logic                                         o_done,
    output logic [tdpt_pkg::divisor_bits(WORD_BITS)-1:0] o_rem
);

    localparam int D_BITS   = tdpt_pkg::divisor_bits(WORD_BITS);
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  n_cnt;
    logic                 r_done;
    logic                 n_done;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-1:0] n_quo;
    logic [D_BITS-1:0]    r_rem;
    logic [D_BITS-1:0]    n_rem;
    logic [D_BITS:0]      trial;
    logic [D_BITS:0]      diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[WORD_BITS-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_comb begin
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = CNT_BITS'(WORD_BITS);
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CNT_BITS'(1);
            n_quo  = {r_quo[WORD_BITS-2:0], 1'b0};
            n_done = (r_cnt == CNT_BITS'(1));
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = diff[D_BITS-1:0];
            end else begin
                n_rem = trial[D_BITS-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[design/trial_division_prime_test_top.sv]
// Trial-division primality test.
// Input: raise start with i_candidate_value while busy is low; the transaction
// is taken at that clock edge and busy stays high until the answer is out.
// Output: o_done is high for exactly one cycle with o_is_prime valid in the
// same cycle; the receiver cannot hold it off and must take it then.
// Divisors 2, 3, 4, ... are tried while the divisor squared is at most the
// value; a zero remainder ends the test with not prime. Zero and one are
// reported as not prime.
// Timing: each trial divisor takes a bound check in S_BOUND and then a pass
// through the bit-serial remainder unit (one dividend bit per cycle) in S_DIV.
// One transaction at a time.
// Reset: clears the sequencer and the strobe; the block is idle afterward and
// no result is produced for a transaction cut short by reset.
module trial_division_prime_test_top #(
    parameter int WORD_BITS = tdpt_pkg::DEFAULT_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_candidate_value,
    output logic                 o_done,
    output logic                 o_is_prime
);

    localparam int D_BITS = tdpt_pkg::divisor_bits(WORD_BITS);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;

    logic [WORD_BITS-1:0] r_n;
    logic [WORD_BITS-1:0] n_n;
    logic [D_BITS-1:0]    r_d;
    logic [D_BITS-1:0]    n_d;
    logic [WORD_BITS:0]   r_sq;
    logic [WORD_BITS:0]   n_sq;
    logic                 r_done;
    logic                 n_done;
    logic                 r_is_prime;
    logic                 n_is_prime;

    logic                 div_start;
    logic                 div_done;
    logic [D_BITS-1:0]    div_rem;
    logic [WORD_BITS:0]   sq_step;

    // remainder unit shared by all trial divisors
    tdpt_rem_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // (d + 1)^2 = d^2 + 2d + 1
    assign sq_step = r_sq + (WORD_BITS + 1)'({r_d, 1'b1});

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_d        = r_d;
        n_sq       = r_sq;
        n_done     = 1'b0;
        n_is_prime = r_is_prime;
        div_start  = 1'b0;
        unique case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (start) begin
                    n_n     = i_candidate_value;
                    n_d     = D_BITS'(tdpt_pkg::FIRST_DIVISOR);
                    n_sq    = (WORD_BITS + 1)'(tdpt_pkg::FIRST_DIVISOR
                                               * tdpt_pkg::FIRST_DIVISOR);
                    n_state = tdpt_pkg::S_BOUND;
                end
            end
            tdpt_pkg::S_BOUND: begin
                if (r_n < WORD_BITS'(tdpt_pkg::FIRST_DIVISOR)) begin
                    n_done     = 1'b1;
                    n_is_prime = 1'b0;
                    n_state    = tdpt_pkg::S_IDLE;
                end else if (r_sq > {1'b0, r_n}) begin
                    n_done     = 1'b1;
                    n_is_prime = 1'b1;
                    n_state    = tdpt_pkg::S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = tdpt_pkg::S_DIV;
                end
            end
            tdpt_pkg::S_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_done     = 1'b1;
                        n_is_prime = 1'b0;
                        n_state    = tdpt_pkg::S_IDLE;
                    end else begin
                        n_d     = r_d + D_BITS'(1);
                        n_sq    = sq_step;
                        n_state = tdpt_pkg::S_BOUND;
                    end
                end
            end
            default: begin
                n_state = tdpt_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // operand, divisor, square and result
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_d        <= n_d;
        r_sq       <= n_sq;
        r_is_prime <= n_is_prime;
    end

    assign busy       = (r_state != tdpt_pkg::S_IDLE);
    assign o_done     = r_done;
    assign o_is_prime = r_is_prime;

endmodule
